[rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared codes and types of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  typedef logic [REQ_W-1:0]  req_t;
  typedef logic [STAT_W-1:0] status_t;

  // Operation codes
  localparam req_t OP_MAKE = 2'd0;
  localparam req_t OP_ADD  = 2'd1;
  localparam req_t OP_MUL  = 2'd2;
  localparam req_t OP_SIMP = 2'd3;

  // Result status codes
  localparam status_t ST_OK  = 2'd0;
  localparam status_t ST_DEN = 2'd1;
  localparam status_t ST_OVF = 2'd2;

endpackage

[rtl/rau_if.sv]
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if
// Valid/ready channels for requests and results of the rational unit.
// ----------------------------------------------------------------------------
interface rau_in_if #(
  parameter int WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic [rau_pkg::REQ_W-1:0] req_type;
  logic signed [WIDTH-1:0] num_a;
  logic signed [WIDTH-1:0] den_a;
  logic signed [WIDTH-1:0] num_b;
  logic signed [WIDTH-1:0] den_b;

  modport source (output valid, req_type, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, req_type, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rau_out_if #(
  parameter int WIDTH = 32
);
  logic                       valid;
  logic                       ready;
  logic signed [WIDTH-1:0]    num_out;
  logic [WIDTH-2:0]           den_out;
  logic [rau_pkg::STAT_W-1:0] status;

  modport source (output valid, num_out, den_out, status, input ready);
  modport sink   (input valid, num_out, den_out, status, output ready);
endinterface

[rtl/rational_arithmetic_unit_core.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Rational ALU: make, add, multiply and gcd-simplify on signed fractions.
// ----------------------------------------------------------------------------
// One request at a time: in_ch.ready is high only while the sequencer is
// idle. The multiply, negate, add, gcd and divide steps share one
// adder/subtractor. Per request (W = WIDTH): a zero or invalid
// denominator goes straight to the result register, make negates the
// magnitude if needed, multiply forms two shift-and-add products of W
// steps each, add forms three such products, and simplify runs the
// binary gcd loop (one shift, subtract or swap per cycle) and then two
// restoring divisions of W steps each. A finished result sits in the
// output register, so the next request is taken while the previous
// result waits for transfer.
// Add and multiply do not reduce. A result whose numerator leaves the
// signed W-bit range or whose denominator exceeds 2^(W-1)-1 reports
// overflow with the low bits.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core #(
  parameter int WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  rau_in_if.sink   in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  localparam int AW = 2*WIDTH + 2;
  localparam int CW = $clog2(WIDTH + 1);
  localparam int KW = $clog2(WIDTH);

  typedef enum logic [3:0] {
    S_IDLE, S_GCD, S_DIV1, S_DIV2, S_MUL1, S_NEG1, S_MUL2, S_NEG2,
    S_ADD, S_MUL3, S_FIN
  } state_t;

  state_t           state_r;
  req_t             op_r;
  logic             nsign_r, sb_r, err_r;
  logic [WIDTH-1:0] ma_r, mda_r, mnb_r, mdb_r;
  logic [WIDTH-1:0] x_r, y_r, g_r, dv_r;
  logic [KW-1:0]    k_r;
  logic [CW-1:0]    cnt_r;
  logic [AW-1:0]    acc_r, n_r, d_r, t_r;

  logic             out_valid_r;
  logic [WIDTH-1:0] out_num_r;
  logic [WIDTH-2:0] out_den_r;
  status_t          out_stat_r;

  // Operand magnitudes and signs at the input
  logic [WIDTH-1:0] ma_c, mda_c, mnb_c, mdb_c;
  logic             sa_c, sda_c, sb_c;
  assign sa_c  = in_ch.num_a[WIDTH-1];
  assign sda_c = in_ch.den_a[WIDTH-1];
  assign sb_c  = in_ch.num_b[WIDTH-1];
  assign ma_c  = sa_c  ? WIDTH'(~in_ch.num_a) + WIDTH'(1) : WIDTH'(in_ch.num_a);
  assign mda_c = sda_c ? WIDTH'(~in_ch.den_a) + WIDTH'(1) : WIDTH'(in_ch.den_a);
  assign mnb_c = sb_c  ? WIDTH'(~in_ch.num_b) + WIDTH'(1) : WIDTH'(in_ch.num_b);
  assign mdb_c = in_ch.den_b[WIDTH-1] ? WIDTH'(~in_ch.den_b) + WIDTH'(1)
                                      : WIDTH'(in_ch.den_b);

  logic accept;
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Shared adder operand selection
  logic [AW-1:0]    add_a, add_b, add_sum;
  logic             add_sub, add_neg;
  logic [WIDTH:0]   trial;
  logic [WIDTH-1:0] mc;
  logic             last;

  assign trial = {acc_r[WIDTH-1:0], dv_r[WIDTH-1]};
  assign last  = (cnt_r == CW'(WIDTH - 1));

  always_comb begin
    case (state_r)
      S_MUL1:  mc = ma_r;
      S_MUL2:  mc = mnb_r;
      default: mc = mda_r;
    endcase
  end

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_r)
      S_MUL1, S_MUL2, S_MUL3: begin
        add_a = AW'(acc_r[2*WIDTH:WIDTH]);
        add_b = acc_r[0] ? AW'(mc) : '0;
      end
      S_NEG1: begin
        add_b   = n_r;
        add_sub = 1'b1;
      end
      S_NEG2: begin
        add_b   = t_r;
        add_sub = 1'b1;
      end
      S_ADD: begin
        add_a = n_r;
        add_b = t_r;
      end
      S_GCD: begin
        add_a   = AW'(x_r);
        add_b   = AW'(y_r);
        add_sub = 1'b1;
      end
      S_DIV1, S_DIV2: begin
        add_a   = AW'(trial);
        add_b   = AW'(g_r);
        add_sub = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  rau_addsub #(.AW(AW)) u_addsub (
    .op_a (add_a),
    .op_b (add_b),
    .sub  (add_sub),
    .sum  (add_sum),
    .neg  (add_neg)
  );

  // Step results of the shift-and-add multiply and the restoring divide
  logic [AW-1:0]    mul_nxt;
  logic [WIDTH-1:0] rem_nxt, quo_nxt;
  assign mul_nxt = AW'({1'b0, add_sum[WIDTH:0], acc_r[WIDTH-1:1]});
  assign rem_nxt = add_neg ? trial[WIDTH-1:0] : add_sum[WIDTH-1:0];
  assign quo_nxt = {dv_r[WIDTH-2:0], ~add_neg};

  // Range checks of the finished result
  logic fits_n, fits_d;
  assign fits_n = (&n_r[AW-1:WIDTH-1]) || ~(|n_r[AW-1:WIDTH-1]);
  assign fits_d = ~(|d_r[AW-1:WIDTH-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_ch.req_type;
            ma_r    <= ma_c;
            mda_r   <= mda_c;
            mnb_r   <= mnb_c;
            mdb_r   <= mdb_c;
            sb_r    <= sb_c;
            err_r   <= 1'b0;
            n_r     <= AW'(ma_c);
            d_r     <= AW'(mda_c);
            x_r     <= ma_c;
            y_r     <= mda_c;
            k_r     <= '0;
            cnt_r   <= '0;
            nsign_r <= (sa_c ^ sda_c) && (ma_c != '0);
            if (in_ch.den_a == '0) begin
              err_r   <= 1'b1;
              state_r <= S_FIN;
            end else if (in_ch.req_type == OP_MAKE) begin
              state_r <= S_NEG1;
            end else if (in_ch.req_type == OP_SIMP) begin
              if (ma_c == '0) begin
                // zero numerator reduces to 0/1
                d_r     <= AW'(1);
                state_r <= S_FIN;
              end else begin
                state_r <= S_GCD;
              end
            end else if (sda_c || in_ch.den_b[WIDTH-1] || in_ch.den_b == '0) begin
              err_r   <= 1'b1;
              state_r <= S_FIN;
            end else begin
              if (in_ch.req_type == OP_MUL) begin
                nsign_r <= sa_c ^ sb_c;
                acc_r   <= AW'(mnb_c);
              end else begin
                nsign_r <= sa_c;
                acc_r   <= AW'(mdb_c);
              end
              state_r <= S_MUL1;
            end
          end
        end

        S_GCD: begin
          if (x_r == y_r) begin
            g_r     <= x_r << k_r;
            dv_r    <= n_r[WIDTH-1:0];
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV1;
          end else if (!x_r[0] && !y_r[0]) begin
            x_r <= x_r >> 1;
            y_r <= y_r >> 1;
            k_r <= k_r + KW'(1);
          end else if (!x_r[0]) begin
            x_r <= x_r >> 1;
          end else if (!y_r[0]) begin
            y_r <= y_r >> 1;
          end else if (add_neg) begin
            // keep the larger value in x before subtracting
            x_r <= y_r;
            y_r <= x_r;
          end else begin
            x_r <= add_sum[WIDTH-1:0];
          end
        end

        S_DIV1, S_DIV2: begin
          acc_r <= AW'(rem_nxt);
          dv_r  <= quo_nxt;
          cnt_r <= cnt_r + CW'(1);
          if (last) begin
            cnt_r <= '0;
            if (state_r == S_DIV1) begin
              n_r     <= AW'(quo_nxt);
              dv_r    <= d_r[WIDTH-1:0];
              acc_r   <= '0;
              state_r <= S_DIV2;
            end else begin
              d_r     <= AW'(quo_nxt);
              state_r <= S_NEG1;
            end
          end
        end

        S_MUL1, S_MUL2, S_MUL3: begin
          acc_r <= mul_nxt;
          cnt_r <= cnt_r + CW'(1);
          if (last) begin
            cnt_r <= '0;
            case (state_r)
              S_MUL1: begin
                n_r     <= mul_nxt;
                state_r <= S_NEG1;
              end
              S_MUL2: begin
                t_r     <= mul_nxt;
                state_r <= S_NEG2;
              end
              default: begin
                d_r     <= mul_nxt;
                state_r <= S_FIN;
              end
            endcase
          end
        end

        S_NEG1: begin
          if (nsign_r) begin
            n_r <= add_sum;
          end
          case (op_r)
            OP_ADD: begin
              acc_r   <= AW'(mda_r);
              state_r <= S_MUL2;
            end
            OP_MUL: begin
              acc_r   <= AW'(mdb_r);
              state_r <= S_MUL3;
            end
            default: begin
              state_r <= S_FIN;
            end
          endcase
        end

        S_NEG2: begin
          if (sb_r) begin
            t_r <= add_sum;
          end
          state_r <= S_ADD;
        end

        S_ADD: begin
          n_r     <= add_sum;
          acc_r   <= AW'(mdb_r);
          state_r <= S_MUL3;
        end

        S_FIN: begin
          // hold until the result register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            if (err_r) begin
              out_num_r  <= '0;
              out_den_r  <= '0;
              out_stat_r <= ST_DEN;
            end else begin
              out_num_r  <= n_r[WIDTH-1:0];
              out_den_r  <= d_r[WIDTH-2:0];
              out_stat_r <= (fits_n && fits_d) ? ST_OK : ST_OVF;
            end
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.num_out = out_num_r;
  assign out_ch.den_out = out_den_r;
  assign out_ch.status  = out_stat_r;

endmodule

[rtl/rau_addsub.sv]
// ----------------------------------------------------------------------------
// rau_addsub
// Shared two's complement adder/subtractor of the sequencer datapath.
// ----------------------------------------------------------------------------
module rau_addsub #(
  parameter int AW = 66
) (
  input  logic [AW-1:0] op_a,
  input  logic [AW-1:0] op_b,
  input  logic          sub,
  output logic [AW-1:0] sum,
  output logic          neg
);

  assign sum = op_a + (sub ? ~op_b : op_b) + AW'(sub);
  assign neg = sum[AW-1];

endmodule

[sim/rational_arithmetic_unit_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core_tb
// Self-checking bench for the rational ALU. Directed extremes and every
// operation, then random requests with random idling on both channels;
// each result transfer is compared with a queue of predicted results.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core_tb;
  import rau_pkg::*;

  localparam int W = 32;
  localparam int CYCLE_LIMIT = 900000;
  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF;

  typedef struct packed {
    logic signed [W-1:0] num;
    logic [W-2:0]        den;
    status_t             st;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rau_in_if  #(.WIDTH(W)) in_ch ();
  rau_out_if #(.WIDTH(W)) out_ch ();

  rational_arithmetic_unit_core #(.WIDTH(W)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  frac_res_t pending_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int reqs_sent = 0;
  int cycles = 0;
  bit idle_off = 1'b0;
  int op_count[4];

  // Exact arithmetic on 128 bits is wide enough for every product and sum.
  function automatic frac_res_t fit_result(logic signed [127:0] n, logic signed [127:0] d);
    frac_res_t r;
    bit ok;
    ok = (n >= -(128'sd1 <<< 31)) && (n <= $signed({64'd0, POS_MAX}))
      && (d <= $signed({64'd0, POS_MAX}));
    r.num = n[W-1:0];
    r.den = d[W-2:0];
    r.st  = ok ? ST_OK : ST_OVF;
    return r;
  endfunction

  function automatic frac_res_t predict_frac(req_t op, logic signed [W-1:0] na,
      logic signed [W-1:0] da, logic signed [W-1:0] nb, logic signed [W-1:0] db);
    frac_res_t r;
    logic signed [127:0] n, d, x, y, t;
    r = '0;
    r.st = ST_DEN;
    if (da == 0) return r;
    if (op == OP_MAKE || op == OP_SIMP) begin
      n = na;
      d = da;
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      if (op == OP_SIMP) begin
        // Euclid on magnitudes; d is nonzero so the gcd is too.
        x = (n < 0) ? -n : n;
        y = d;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        n = n / x;
        d = d / x;
      end
      return fit_result(n, d);
    end
    if (da < 0 || db <= 0) return r;
    if (op == OP_ADD)
      n = 128'(na) * 128'(db) + 128'(nb) * 128'(da);
    else
      n = 128'(na) * 128'(nb);
    d = 128'(da) * 128'(db);
    return fit_result(n, d);
  endfunction

  task automatic idle_burst();
    if (!idle_off && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 10)) @(negedge clk);
  endtask

  // Send one request: hold valid until the transfer edge, then predict.
  task automatic send_req(req_t op, logic [W-1:0] na, logic [W-1:0] da,
      logic [W-1:0] nb, logic [W-1:0] db);
    @(negedge clk);
    idle_burst();
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= op;
    in_ch.num_a    <= na;
    in_ch.den_a    <= da;
    in_ch.num_b    <= nb;
    in_ch.den_b    <= db;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_q.push_back(predict_frac(op, na, da, nb, db));
    reqs_sent++;
    op_count[op]++;
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Result sink: random stalls on ready, compare each transfer.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!idle_off && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frac_res_t exp_r;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result num=%0d", out_ch.num_out);
      end else begin
        exp_r = pending_q.pop_front();
        if (out_ch.num_out !== exp_r.num || out_ch.den_out !== exp_r.den
            || out_ch.status !== exp_r.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d st%0d got %0d/%0d st%0d",
                     exp_r.num, exp_r.den, exp_r.st,
                     out_ch.num_out, out_ch.den_out, out_ch.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 40) - 20;
      3: return $urandom_range(0, 4000) - 2000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_make();
    send_req(OP_MAKE, 32'd5, 32'd7, 32'd0, 32'd0);
    send_req(OP_MAKE, 32'd5, -32'sd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_MAKE, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_req(OP_MAKE, 32'd3, 32'h8000_0000, 32'd0, 32'd0);
    send_req(OP_MAKE, 32'd1, 32'd0, 32'd1, 32'd1);
  endtask

  task automatic test_add();
    send_req(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_req(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
    send_req(OP_ADD, 32'd1, -32'sd2, 32'd1, 32'd3);
    send_req(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
    send_req(OP_ADD, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
  endtask

  task automatic test_mul();
    send_req(OP_MUL, -32'sd3, 32'd4, 32'd5, 32'd6);
    send_req(OP_MUL, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
    send_req(OP_MUL, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF);
    send_req(OP_MUL, 32'd1, 32'd2, 32'd1, -32'sd1);
    send_req(OP_MUL, 32'd0, 32'd0, 32'd0, 32'd0);
  endtask

  task automatic test_simplify();
    send_req(OP_SIMP, 32'd12, 32'd18, 32'd0, 32'd0);
    send_req(OP_SIMP, 32'd12, -32'sd18, 32'hFFFF_FFFF, 32'h8000_0000);
    send_req(OP_SIMP, 32'd0, -32'sd9, 32'd0, 32'd0);
    send_req(OP_SIMP, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_req(OP_SIMP, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    send_req(OP_SIMP, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'd0, 32'd0);
    send_req(OP_SIMP, 32'd5, 32'd0, 32'd0, 32'd0);
  endtask

  // Mostly valid denominators so the arithmetic paths are exercised.
  task automatic test_random(int n_items);
    logic [W-1:0] da, db;
    for (int i = 0; i < n_items; i++) begin
      if (i > n_items * 4 / 5) idle_off = 1'b1;
      da = rand_word();
      db = rand_word();
      if ($urandom_range(0, 9) < 8) begin
        da[W-1] = 1'b0;
        db[W-1] = 1'b0;
        if (da == 0) da = 1;
        if (db == 0) db = 1;
      end
      send_req(req_t'($urandom_range(0, 3)), rand_word(), da, rand_word(), db);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = OP_MAKE;
    in_ch.num_a = '0;
    in_ch.den_a = '0;
    in_ch.num_b = '0;
    in_ch.den_b = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_make();
    test_add();
    test_mul();
    test_simplify();
    test_random(650);
    // Drain: wait for every predicted result, then a latency tail.
    while (pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d requests (make %0d add %0d mul %0d simplify %0d), %0d results",
             reqs_sent, op_count[0], op_count[1], op_count[2], op_count[3], results_seen);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[filelist.f]
rtl/rau_pkg.sv
rtl/rau_if.sv
rtl/rau_addsub.sv
rtl/rational_arithmetic_unit_core.sv
sim/rational_arithmetic_unit_core_tb.sv
